@@ hw/rtl/trlb_pkg.sv @@
package trlb_pkg;

	localparam int DEPTH_DEF      = 16;
	localparam int DATA_WIDTH_DEF = 32;

	localparam logic FUNC_ADD = 1'b0;
	localparam logic FUNC_GET = 1'b1;

	typedef struct packed {
		logic        func;
		logic [31:0] payload_in;
		logic [31:0] seq_in;
		logic [31:0] release_time;
		logic [31:0] current_time;
	} req_t;

	typedef struct packed {
		logic [31:0] data_out;
		logic        arrived;
		logic        dropped;
	} rsp_t;

endpackage

@@ hw/rtl/trlb_ram.sv @@
module trlb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hw/rtl/timed_release_latest_buffer.sv @@
// Delay buffer for simulated link latency. A request with func add stores a payload with its
// sequence number and release time, kept in release-time order behind any equal times; a
// request with func get drops every entry released by current_time and reports the newest
// payload seen so far. Each request gives exactly one result, strobed by result_valid for one
// cycle right after the request finishes; the receiver cannot stall it. busy is high while a
// request is at work. An add on a full table drops its entry and one on an empty table stores
// it straight from idle; otherwise the add reads and compares entries from the tail, moving
// each later one back a slot, and ends with a final write when it lands at the head. A get on
// an empty table answers from idle; otherwise it reads and compares entries from the head. Each
// step has a read and a compare state: the single entry memory has one registered read port.
// After reset the table is empty at once; no clearing pass is needed.
module timed_release_latest_buffer #(
	parameter int DEPTH      = trlb_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = trlb_pkg::DATA_WIDTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  trlb_pkg::req_t req,
	output logic           result_valid,
	output trlb_pkg::rsp_t result
);

	import trlb_pkg::*;

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int EW = DATA_WIDTH + 64;

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_ADD_RD  = 3'd1;
	localparam logic [2:0] ST_ADD_CMP = 3'd2;
	localparam logic [2:0] ST_ADD_FIN = 3'd3;
	localparam logic [2:0] ST_GET_RD  = 3'd4;
	localparam logic [2:0] ST_GET_CMP = 3'd5;

	logic [2:0]            state_q;
	logic [CW-1:0]         count_q;
	logic [IW-1:0]         head_q;
	logic [IW-1:0]         k_q;
	logic [DATA_WIDTH-1:0] last_pay_q;
	logic [31:0]           last_seq_q;
	logic [DATA_WIDTH-1:0] pick_pay_q;
	logic [31:0]           pick_seq_q;
	req_t                  req_q;
	rsp_t                  result_q;
	logic                  result_valid_q;

	logic                  mem_we;
	logic [IW-1:0]         mem_waddr;
	logic [EW-1:0]         mem_wdata;
	logic [IW-1:0]         mem_raddr;
	logic [EW-1:0]         rd_word;
	logic [31:0]           rd_time;
	logic [31:0]           rd_seq;
	logic [DATA_WIDTH-1:0] rd_pay;
	logic [DATA_WIDTH-1:0] npick_pay;
	logic [31:0]           npick_seq;
	logic [CW-1:0]         k_next;

	function automatic logic [IW-1:0] phys(input logic [IW-1:0] head, input logic [CW-1:0] off);
		logic [CW:0] sum;
		sum = (CW+1)'(head) + (CW+1)'(off);
		if (sum >= (CW+1)'(DEPTH)) begin
			sum = sum - (CW+1)'(DEPTH);
		end
		return sum[IW-1:0];
	endfunction

	assign busy         = (state_q != ST_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	assign rd_pay  = rd_word[DATA_WIDTH-1:0];
	assign rd_seq  = rd_word[DATA_WIDTH+31:DATA_WIDTH];
	assign rd_time = rd_word[DATA_WIDTH+63:DATA_WIDTH+32];
	assign k_next  = CW'(k_q) + CW'(1);

	always_comb begin
		if (rd_seq > pick_seq_q) begin
			npick_seq = rd_seq;
			npick_pay = rd_pay;
		end else begin
			npick_seq = pick_seq_q;
			npick_pay = pick_pay_q;
		end
	end

	always_comb begin
		mem_raddr = phys(head_q, CW'(k_q));
		mem_we    = 1'b0;
		mem_waddr = head_q;
		mem_wdata = {req_q.release_time, req_q.seq_in, DATA_WIDTH'(req_q.payload_in)};
		unique case (state_q) inside
			ST_IDLE: begin
				mem_wdata = {req.release_time, req.seq_in, DATA_WIDTH'(req.payload_in)};
				mem_we    = start && (req.func == FUNC_ADD) && (count_q == '0);
			end
			ST_ADD_CMP: begin
				mem_we    = 1'b1;
				mem_waddr = phys(head_q, k_next);
				if (req_q.release_time < rd_time) begin
					mem_wdata = rd_word;
				end
			end
			ST_ADD_FIN: begin
				mem_we = 1'b1;
			end
			ST_ADD_RD, ST_GET_RD, ST_GET_CMP: begin
				mem_we = 1'b0;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	trlb_ram #(
		.WIDTH(EW),
		.DEPTH(DEPTH)
	) u_entries (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(rd_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			count_q        <= '0;
			head_q         <= '0;
			last_pay_q     <= '0;
			last_seq_q     <= '0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						req_q <= req;
						if (req.func == FUNC_ADD) begin
							if (count_q == CW'(DEPTH)) begin
								result_valid_q    <= 1'b1;
								result_q.data_out <= 32'(last_pay_q);
								result_q.arrived  <= 1'b0;
								result_q.dropped  <= 1'b1;
							end else if (count_q == '0) begin
								count_q           <= CW'(1);
								result_valid_q    <= 1'b1;
								result_q.data_out <= 32'(last_pay_q);
								result_q.arrived  <= 1'b0;
								result_q.dropped  <= 1'b0;
							end else begin
								k_q     <= IW'(count_q - CW'(1));
								state_q <= ST_ADD_RD;
							end
						end else begin
							if (count_q == '0) begin
								result_valid_q    <= 1'b1;
								result_q.data_out <= 32'(last_pay_q);
								result_q.arrived  <= 1'b0;
								result_q.dropped  <= 1'b0;
							end else begin
								k_q        <= '0;
								pick_seq_q <= last_seq_q;
								pick_pay_q <= last_pay_q;
								state_q    <= ST_GET_RD;
							end
						end
					end
				end
				ST_ADD_RD: begin
					state_q <= ST_ADD_CMP;
				end
				ST_ADD_CMP: begin
					if (req_q.release_time < rd_time) begin
						if (k_q == '0) begin
							state_q <= ST_ADD_FIN;
						end else begin
							k_q     <= k_q - IW'(1);
							state_q <= ST_ADD_RD;
						end
					end else begin
						count_q           <= count_q + CW'(1);
						result_valid_q    <= 1'b1;
						result_q.data_out <= 32'(last_pay_q);
						result_q.arrived  <= 1'b0;
						result_q.dropped  <= 1'b0;
						state_q           <= ST_IDLE;
					end
				end
				ST_ADD_FIN: begin
					count_q           <= count_q + CW'(1);
					result_valid_q    <= 1'b1;
					result_q.data_out <= 32'(last_pay_q);
					result_q.arrived  <= 1'b0;
					result_q.dropped  <= 1'b0;
					state_q           <= ST_IDLE;
				end
				ST_GET_RD: begin
					state_q <= ST_GET_CMP;
				end
				ST_GET_CMP: begin
					if (rd_time <= req_q.current_time) begin
						if (k_next == count_q) begin
							head_q            <= phys(head_q, count_q);
							count_q           <= '0;
							last_pay_q        <= npick_pay;
							last_seq_q        <= npick_seq;
							result_valid_q    <= 1'b1;
							result_q.data_out <= 32'(npick_pay);
							result_q.arrived  <= 1'b1;
							result_q.dropped  <= 1'b0;
							state_q           <= ST_IDLE;
						end else begin
							pick_pay_q <= npick_pay;
							pick_seq_q <= npick_seq;
							k_q        <= k_q + IW'(1);
							state_q    <= ST_GET_RD;
						end
					end else begin
						result_valid_q   <= 1'b1;
						result_q.dropped <= 1'b0;
						if (k_q == '0) begin
							result_q.data_out <= 32'(last_pay_q);
							result_q.arrived  <= 1'b0;
						end else begin
							head_q            <= phys(head_q, CW'(k_q));
							count_q           <= count_q - CW'(k_q);
							last_pay_q        <= pick_pay_q;
							last_seq_q        <= pick_seq_q;
							result_q.data_out <= 32'(pick_pay_q);
							result_q.arrived  <= 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count exceeds table depth");

	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> (state_q == ST_IDLE))
		else $error("result strobed while a request is still at work");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && result_q.dropped) |-> (count_q == CW'(DEPTH)))
		else $error("add dropped although the table had room");

	a_arrive_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && result_q.arrived) |-> (count_q < $past(count_q)))
		else $error("get released entries without shrinking the table");

	a_no_write_on_get: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> !(state_q == ST_GET_RD || state_q == ST_GET_CMP))
		else $error("entry memory written during a get");

endmodule

@@ tb/sv/tb_timed_release_latest_buffer.sv @@
module tb_timed_release_latest_buffer;
	import trlb_pkg::*;

	localparam int DEPTH = DEPTH_DEF;
	localparam int N_PLAN = 16;
	localparam int N_RANDOM = 650;
	localparam int SETTLE_CYCLES = 2 * DEPTH + 8;

	typedef struct packed {
		logic        func;
		logic [31:0] payload;
		logic [31:0] seq;
		logic [31:0] rtime;
		logic [31:0] now;
		int          reps;
		bit          typed;
		rsp_t        want;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	req_t req = '0;
	logic busy;
	logic result_valid;
	rsp_t result;

	logic [31:0] pend_time [DEPTH];
	logic [31:0] pend_seq [DEPTH];
	logic [31:0] pend_payload [DEPTH];
	int pend_count = 0;
	logic [31:0] shown_payload = '0;
	logic [31:0] shown_seq = '0;

	rsp_t expected_rsp [$];
	rsp_t want_rsp;
	int errors = 0;
	bit no_idle = 1'b0;

	// The entry with sequence number all ones stays parked at the latest possible
	// time until the closing get, so it never freezes the held output early.
	plan_row_t plan [N_PLAN] = '{
		'{FUNC_GET, 32'h0, 32'h0, 32'h0, 32'h0, 1, 1'b1, '{32'h0, 1'b0, 1'b0}},
		'{FUNC_ADD, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 1, 1'b1, '{32'h0, 1'b0, 1'b0}},
		'{FUNC_GET, 32'h0, 32'h0, 32'h0, 32'h0, 1, 1'b1, '{32'h0, 1'b1, 1'b0}},
		'{FUNC_ADD, 32'hA5A5_A5A5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 1, 1'b1,
			'{32'h0, 1'b0, 1'b0}},
		'{FUNC_ADD, 32'h1, 32'd5, 32'd10, 32'h0, 1, 1'b0, '0},
		'{FUNC_ADD, 32'h2, 32'd5, 32'd10, 32'h0, 1, 1'b0, '0},
		'{FUNC_ADD, 32'h3, 32'd3, 32'd5, 32'h0, 1, 1'b0, '0},
		'{FUNC_GET, 32'h0, 32'h0, 32'h0, 32'd9, 1, 1'b0, '0},
		'{FUNC_GET, 32'h0, 32'h0, 32'h0, 32'd10, 1, 1'b0, '0},
		'{FUNC_ADD, 32'h0, 32'd4, 32'h0, 32'h0, 1, 1'b0, '0},
		'{FUNC_GET, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFE, 1, 1'b0, '0},
		'{FUNC_ADD, 32'h100, 32'd6, 32'd1000, 32'h0, DEPTH - 1, 1'b0, '0},
		'{FUNC_ADD, 32'hDEAD_BEEF, 32'd100, 32'h0, 32'h0, 1, 1'b1, '{32'h1, 1'b0, 1'b1}},
		'{FUNC_GET, 32'h0, 32'h0, 32'h0, 32'd994, 1, 1'b0, '0},
		'{FUNC_ADD, 32'h0, 32'h0, 32'h0, 32'h0, 1, 1'b0, '0},
		'{FUNC_GET, 32'h0, 32'h0, 32'h0, 32'd999, 1, 1'b0, '0}
	};

	always #5 clk = ~clk;

	timed_release_latest_buffer dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.result_valid(result_valid),
		.result(result)
	);

	function automatic rsp_t buffer_step(req_t r);
		rsp_t rsp;
		int pos;
		int n;
		logic [31:0] pick_payload;
		logic [31:0] pick_seq;
		rsp = '{data_out: shown_payload, arrived: 1'b0, dropped: 1'b0};
		if (r.func == FUNC_ADD) begin
			if (pend_count >= DEPTH) begin
				rsp.dropped = 1'b1;
				return rsp;
			end
			pos = pend_count;
			for (int k = 0; k < pend_count; k++) begin
				if (r.release_time < pend_time[k]) begin
					pos = k;
					break;
				end
			end
			for (int k = pend_count; k > pos; k--) begin
				pend_time[k] = pend_time[k - 1];
				pend_seq[k] = pend_seq[k - 1];
				pend_payload[k] = pend_payload[k - 1];
			end
			pend_time[pos] = r.release_time;
			pend_seq[pos] = r.seq_in;
			pend_payload[pos] = r.payload_in;
			pend_count++;
		end else begin
			n = 0;
			pick_payload = shown_payload;
			pick_seq = shown_seq;
			while (n < pend_count && pend_time[n] <= r.current_time) begin
				if (pend_seq[n] > pick_seq) begin
					pick_seq = pend_seq[n];
					pick_payload = pend_payload[n];
				end
				n++;
			end
			if (n != 0) begin
				for (int k = n; k < pend_count; k++) begin
					pend_time[k - n] = pend_time[k];
					pend_seq[k - n] = pend_seq[k];
					pend_payload[k - n] = pend_payload[k];
				end
				pend_count -= n;
				shown_payload = pick_payload;
				shown_seq = pick_seq;
				rsp.data_out = pick_payload;
				rsp.arrived = 1'b1;
			end
		end
		return rsp;
	endfunction

	task automatic send_request(req_t r, bit typed, rsp_t typed_rsp);
		rsp_t predicted;
		int gap;
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy);
		predicted = buffer_step(r);
		expected_rsp.insert(expected_rsp.size(), typed ? typed_rsp : predicted);
		gap = no_idle ? 0 : $urandom_range(0, 14);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (expected_rsp.size() == 0) begin
				$error("result with no request pending: data_out %h", result.data_out);
				errors++;
			end else begin
				want_rsp = expected_rsp.pop_front();
				if (result.data_out !== want_rsp.data_out) begin
					$error("data_out: expected %h, got %h", want_rsp.data_out, result.data_out);
					errors++;
				end
				if (result.arrived !== want_rsp.arrived) begin
					$error("arrived: expected %b, got %b", want_rsp.arrived, result.arrived);
					errors++;
				end
				if (result.dropped !== want_rsp.dropped) begin
					$error("dropped: expected %b, got %b", want_rsp.dropped, result.dropped);
					errors++;
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		req_t r;
		bit filling;
		bit noise;
		logic [31:0] link_time;
		logic [31:0] seq_top;
		int waited;
		filling = 1'b1;
		link_time = '0;
		seq_top = 32'd30;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			for (int k = 0; k < plan[i].reps; k++) begin
				r = '0;
				r.func = plan[i].func;
				r.payload_in = plan[i].payload + k;
				r.seq_in = plan[i].seq + k;
				r.release_time = plan[i].rtime - k;
				r.current_time = plan[i].now;
				send_request(r, plan[i].typed, plan[i].want);
			end
		end

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i % 50 == 0)
				no_idle = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 39) == 0)
				filling = !filling;
			noise = ($urandom_range(0, 9) == 0);
			r.payload_in = $urandom;
			r.seq_in = $urandom;
			r.release_time = $urandom;
			r.current_time = $urandom;
			r.func = ($urandom_range(0, 99) < (filling ? 80 : 35)) ? FUNC_ADD : FUNC_GET;
			if (r.func == FUNC_ADD) begin
				case ($urandom_range(0, 9))
					0: r.seq_in = (seq_top > 40) ? seq_top - $urandom_range(0, 40) : seq_top;
					1: r.seq_in = seq_top;
					default: begin
						if (seq_top > 32'hF000_0000)
							seq_top += $urandom_range(1, 1000);
						else
							seq_top += $urandom_range(1, 32'h01FF_FFFF);
						r.seq_in = seq_top;
					end
				endcase
				if (!noise)
					r.release_time = link_time + $urandom_range(0, 60);
			end else begin
				if (!noise)
					r.current_time = link_time;
				else if (r.current_time == 32'hFFFF_FFFF)
					r.current_time = 32'hFFFF_FFFE;
			end
			link_time += $urandom_range(0, 8);
			send_request(r, 1'b0, '0);
		end

		r = '0;
		r.func = FUNC_GET;
		r.current_time = 32'hFFFF_FFFF;
		send_request(r, 1'b0, '0);
		start <= 1'b0;

		waited = 0;
		while (expected_rsp.size() != 0 && waited < 2000) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_rsp.size() != 0) begin
			$error("%0d results never arrived", expected_rsp.size());
			errors++;
		end
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
